@@ rtl/point_in_polygon_test_core_assert.svh @@
// Assertion macros for the point-in-polygon core checkers
`ifndef POINT_IN_POLYGON_TEST_CORE_ASSERT_SVH
`define POINT_IN_POLYGON_TEST_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define PIP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define PIP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/pip_pkg.sv @@
// Shared constants and types for the point-in-polygon core
package pip_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_WIDTH  = 32;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int DIFF_W       = COORD_WIDTH + 1;
  localparam int PROD_W       = 2 * DIFF_W;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [ADDR_W-1:0]             addr_t;
  typedef logic [CNT_W-1:0]              count_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } vertex_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  // one edge (prev -> cur) handed to the crossing unit
  typedef struct packed {
    logic    valid;
    vertex_t cur;
    vertex_t prev;
  } edge_req_t;

  typedef struct packed {
    logic busy;
    logic hit;
  } edge_stat_t;

endpackage

@@ rtl/pip_ifs.sv @@
// Valid/ready channel interfaces for the point-in-polygon core
interface pip_in_if;
  logic            valid;
  logic            ready;
  logic            opcode;
  logic            first_vertex;
  pip_pkg::coord_t coord_x;
  pip_pkg::coord_t coord_y;

  modport source (output valid, output opcode, output first_vertex,
                  output coord_x, output coord_y, input ready);
  modport sink   (input valid, input opcode, input first_vertex,
                  input coord_x, input coord_y, output ready);
  modport monitor (input valid, input ready, input opcode, input first_vertex,
                   input coord_x, input coord_y);
endinterface

interface pip_out_if;
  logic                   valid;
  logic                   ready;
  logic                   inside_res;
  logic                   load_refused;
  logic [pip_pkg::CNT_W-1:0] stored_vertices;

  modport source (output valid, output inside_res, output load_refused,
                  output stored_vertices, input ready);
  modport sink   (input valid, input inside_res, input load_refused,
                  input stored_vertices, output ready);
  modport monitor (input valid, input ready, input inside_res, input load_refused,
                   input stored_vertices);
endinterface

@@ rtl/pip_vtx_mem.sv @@
// Vertex memory: one write port, one registered read port
module pip_vtx_mem (
  input  logic             clk,
  input  logic             we,
  input  pip_pkg::addr_t   waddr,
  input  pip_pkg::vertex_t wdata,
  input  pip_pkg::addr_t   raddr,
  output pip_pkg::vertex_t rdata
);
  import pip_pkg::*;

  vertex_t mem [MAX_VERTICES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/pip_edge.sv @@
// Edge crossing unit: differences, cross products, signed compare
module pip_edge (
  input  logic               clk,
  input  logic               rst_n,
  input  pip_pkg::edge_req_t req,
  input  pip_pkg::coord_t    qx,
  input  pip_pkg::coord_t    qy,
  output pip_pkg::edge_stat_t stat
);
  import pip_pkg::*;

  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  diff_t dyi, dxji, dxi, dyji;
  logic  cond, dir;

  logic  a_v_r, b_v_r;
  diff_t a_dyi_r, a_dxji_r, a_dxi_r, a_dyji_r;
  logic  a_cond_r, a_dir_r;
  prod_t b_lhs_r, b_rhs_r;
  logic  b_cond_r, b_dir_r;

  // stage A: differences and the straddle test
  always_comb begin
    dyi  = diff_t'(qy)          - diff_t'(req.cur.y);
    dxji = diff_t'(req.prev.x)  - diff_t'(req.cur.x);
    dxi  = diff_t'(qx)          - diff_t'(req.cur.x);
    dyji = diff_t'(req.prev.y)  - diff_t'(req.cur.y);
    cond = ((req.cur.y < qy) && (req.prev.y >= qy)) ||
           ((req.prev.y < qy) && (req.cur.y >= qy));
    dir  = req.prev.y > req.cur.y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      a_v_r <= req.valid;
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    a_dyi_r  <= dyi;
    a_dxji_r <= dxji;
    a_dxi_r  <= dxi;
    a_dyji_r <= dyji;
    a_cond_r <= cond;
    a_dir_r  <= dir;
    // stage B: exact cross products, no division
    b_lhs_r  <= prod_t'(a_dyi_r) * prod_t'(a_dxji_r);
    b_rhs_r  <= prod_t'(a_dxi_r) * prod_t'(a_dyji_r);
    b_cond_r <= a_cond_r;
    b_dir_r  <= a_dir_r;
  end

  // stage C: compare sense flips with the edge direction
  always_comb begin
    stat.busy = req.valid | a_v_r | b_v_r;
    stat.hit  = b_v_r && b_cond_r &&
                (b_dir_r ? (b_lhs_r < b_rhs_r) : (b_rhs_r < b_lhs_r));
  end

endmodule

@@ rtl/point_in_polygon_test_core.sv @@
// Top level of the even-odd point-in-polygon core
//
//  channel  | dir | payload                                     | beat
//  in_ch    | in  | opcode, first_vertex, coord_x, coord_y      | valid & ready
//  out_ch   | out | inside_res, load_refused, stored_vertices   | valid & ready
//
// One item at a time. A load goes to the result register through the finish state;
// a query over n vertices takes one vertex memory read per edge, through
// the registered read port and the three-stage crossing unit.
// The next item is taken once the core is back in idle.
// Reset (rst_n low, synchronous) clears the vertex count; memory is not cleared.
// A result held on out_ch does not block accepting the next item; the
// finished item then waits until the result register is free.
module point_in_polygon_test_core (
  input  logic      clk,
  input  logic      rst_n,
  pip_in_if.sink    in_ch,
  pip_out_if.source out_ch
);
  import pip_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PRIME = 5'b00010,
    ST_WALK  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

  state_t     state_r, state_nxt;
  count_t     count_r, count_nxt;
  addr_t      idx_r, idx_nxt;
  logic       parity_r, parity_nxt;
  logic       refused_r;
  logic       rd_prime_r, rd_edge_r;
  coord_t     qx_r, qy_r;
  vertex_t    prev_r;

  logic       out_valid_r, out_inside_r, out_refused_r;
  count_t     out_count_r;

  logic       in_acc, is_load, refuse, mem_we, out_free;
  count_t     last_cnt;
  addr_t      last_addr, waddr, raddr;
  vertex_t    wdata, rdata;
  edge_req_t  ereq;
  edge_stat_t estat;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid & in_ch.ready;
  assign is_load     = (opcode_t'(in_ch.opcode) == OP_LOAD);
  assign refuse      = !in_ch.first_vertex && (count_r == count_t'(MAX_VERTICES));
  assign mem_we      = in_acc && is_load && !refuse;
  assign waddr       = in_ch.first_vertex ? '0 : count_r[ADDR_W-1:0];
  assign wdata.x     = in_ch.coord_x;
  assign wdata.y     = in_ch.coord_y;
  assign last_cnt    = count_r - count_t'(1);
  assign last_addr   = last_cnt[ADDR_W-1:0];
  assign raddr       = (state_r == ST_PRIME) ? last_addr : idx_r;
  assign out_free    = !out_valid_r || out_ch.ready;

  pip_vtx_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign ereq.valid = rd_edge_r;
  assign ereq.cur   = rdata;
  assign ereq.prev  = prev_r;

  pip_edge u_edge (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ereq),
    .qx    (qx_r),
    .qy    (qy_r),
    .stat  (estat)
  );

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    parity_nxt = estat.hit ? ~parity_r : parity_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          parity_nxt = 1'b0;
          if (is_load) begin
            if (in_ch.first_vertex) begin
              count_nxt = count_t'(1);
            end else if (!refuse) begin
              count_nxt = count_r + count_t'(1);
            end
            state_nxt = ST_FIN;
          end else if (count_r == '0) begin
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_PRIME;
          end
        end
      end
      ST_PRIME: begin
        idx_nxt   = '0;
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        idx_nxt = idx_r + addr_t'(1);
        if (idx_r == last_addr) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!estat.busy) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      parity_r    <= 1'b0;
      rd_prime_r  <= 1'b0;
      rd_edge_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      parity_r   <= parity_nxt;
      rd_prime_r <= (state_r == ST_PRIME);
      rd_edge_r  <= (state_r == ST_WALK);
      if ((state_r == ST_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (in_acc) begin
      qx_r      <= in_ch.coord_x;
      qy_r      <= in_ch.coord_y;
      refused_r <= is_load && refuse;
    end
    // previous vertex trails the read stream by one beat
    if (rd_prime_r || rd_edge_r) begin
      prev_r <= rdata;
    end
    if ((state_r == ST_FIN) && out_free) begin
      out_inside_r  <= parity_r;
      out_refused_r <= refused_r;
      out_count_r   <= count_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.inside_res      = out_inside_r;
  assign out_ch.load_refused    = out_refused_r;
  assign out_ch.stored_vertices = out_count_r;

endmodule

@@ rtl/pip_chk.sv @@
// Port-level checker for the point-in-polygon core, with its bind
`include "point_in_polygon_test_core_assert.svh"

module pip_chk (
  input logic       clk,
  input logic       rst_n,
  pip_in_if.sink    in_ch,
  pip_out_if.source out_ch
);
  import pip_pkg::*;

  // one item at a time: an accepted input beat drops ready
  `PIP_ASSERT_NXT(a_one_item, in_ch.valid && in_ch.ready, !in_ch.ready, "input taken while busy")

  // a stalled result beat keeps its payload
  `PIP_ASSERT_NXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.inside_res) && $stable(out_ch.load_refused) && $stable(out_ch.stored_vertices), "result beat changed while stalled")

  `PIP_ASSERT_IMP(a_count_range, out_ch.valid, out_ch.stored_vertices <= CNT_W'(MAX_VERTICES), "vertex count beyond capacity")

  // refusal only with a full memory, never together with an inside answer
  `PIP_ASSERT_IMP(a_refuse_full, out_ch.valid && out_ch.load_refused, out_ch.stored_vertices == CNT_W'(MAX_VERTICES) && !out_ch.inside_res, "refusal without full memory")

  // two vertices cross the ray an even number of times
  `PIP_ASSERT_IMP(a_inside_poly, out_ch.valid && out_ch.inside_res, out_ch.stored_vertices >= CNT_W'(3) && !out_ch.load_refused, "inside answer with fewer than three vertices")

endmodule

bind point_in_polygon_test_core pip_chk u_pip_chk (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);
